FILE: hdl/rmd_pkg.sv
package rmd_pkg;

   // line buffer depth and frame limits
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // fixed field widths
   localparam int DIM_W      = 13;
   localparam int NUM_CHAN   = 4;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = NUM_CHAN * CHAN_W;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register indexes (paddr[2])
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic [COL_W-1:0] col_type;
   typedef logic [ROW_W-1:0] row_type;
   typedef logic [DIM_W-1:0] dim_type;

   // line buffer access issued when a word is accepted
   typedef struct packed {
      logic      en;
      logic      we;
      col_type   addr;
      pixel_type wdata;
   } ram_cmd_type;

   // per-word info carried next to the line buffer read
   typedef struct packed {
      logic      valid;
      logic      odd_col;
      logic      frame_end;
      pixel_type pix;
   } tag_type;

   // per-byte rounding average of two packed pixels
   function automatic pixel_type avg_pixel(pixel_type a, pixel_type b);
      pixel_type         r;
      logic [CHAN_W:0]   s;
      for (int k = 0; k < NUM_CHAN; k++) begin
         s = {1'b0, a[k*CHAN_W +: CHAN_W]} + {1'b0, b[k*CHAN_W +: CHAN_W]}
             + {{CHAN_W{1'b0}}, 1'b1};
         r[k*CHAN_W +: CHAN_W] = s[CHAN_W:1];
      end
      return r;
   endfunction

endpackage

FILE: hdl/rmd_if.sv
// source pixel channel
interface rmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] chan0;
   logic [7:0] chan1;
   logic [7:0] chan2;
   logic [7:0] chan3;

   modport source (output valid, output chan0, output chan1, output chan2, output chan3,
                   input ready);
   modport sink (input valid, input chan0, input chan1, input chan2, input chan3,
                 output ready);
endinterface

// downsampled pixel channel
interface rmd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_chan0;
   logic [7:0] out_chan1;
   logic [7:0] out_chan2;
   logic [7:0] out_chan3;
   logic       frame_end;

   modport source (output valid, output out_chan0, output out_chan1, output out_chan2,
                   output out_chan3, output frame_end, input ready);
   modport sink (input valid, input out_chan0, input out_chan1, input out_chan2,
                 input out_chan3, input frame_end, output ready);
endinterface

FILE: hdl/rgba_mipmap_downsample_2x2_unit.sv
// channel   dir  handshake      word
// req       in   valid/ready    chan0..chan3, one source pixel
// rsp       out  valid/ready    out_chan0..out_chan3, frame_end
// csr       in   APB write/read image_width (0x0), image_height (0x4)
//
// One source pixel is taken every cycle unless a stalled output holds the read stage;
// the single line buffer port does one write (even row) or one read (odd row) per pixel.
// The last pixel of a block is registered beside the line buffer read, then its result goes to the output register.
// Reset clears the counters and held average; the line buffer is not
// cleared, every odd-row read follows the write of the row above.
// A stalled output backs up into the read stage and then drops req.ready.
module rgba_mipmap_downsample_2x2_unit (
   input  logic                            clock,
   input  logic                            reset,
   rmd_req_if.sink                         req,
   rmd_rsp_if.source                       rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rmd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [rmd_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [rmd_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   rmd_pkg::dim_type     width_ff, width_in;
   rmd_pkg::dim_type     height_ff, height_in;
   logic                 csr_write;
   logic                 advance;
   rmd_pkg::ram_cmd_type ram_cmd;
   rmd_pkg::tag_type     tag;
   rmd_pkg::pixel_type   above;

   // configuration registers; any write restarts the frame
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (paddr[2])
            rmd_pkg::REG_IMAGE_WIDTH:  width_in  = pwdata[rmd_pkg::DIM_W-1:0];
            rmd_pkg::REG_IMAGE_HEIGHT: height_in = pwdata[rmd_pkg::DIM_W-1:0];
            default:                   width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rmd_pkg::DIM_W'(2);
         height_ff <= rmd_pkg::DIM_W'(2);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         rmd_pkg::REG_IMAGE_WIDTH:
            prdata = {{(rmd_pkg::CSR_DATA_W-rmd_pkg::DIM_W){1'b0}}, width_ff};
         rmd_pkg::REG_IMAGE_HEIGHT:
            prdata = {{(rmd_pkg::CSR_DATA_W-rmd_pkg::DIM_W){1'b0}}, height_ff};
         default:
            prdata = '0;
      endcase
   end

   rmd_scan_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_write),
      .image_width  (width_ff),
      .image_height (height_ff),
      .advance      (advance),
      .req          (req),
      .ram_cmd      (ram_cmd),
      .tag          (tag)
   );

   rmd_line_ram #(
      .DEPTH (rmd_pkg::MAX_WIDTH),
      .WIDTH (rmd_pkg::PIX_W)
   ) u_line_ram (
      .clock (clock),
      .en    (ram_cmd.en),
      .we    (ram_cmd.we),
      .addr  (ram_cmd.addr),
      .wdata (ram_cmd.wdata),
      .rdata (above)
   );

   rmd_filter u_filter (
      .clock   (clock),
      .reset   (reset),
      .tag     (tag),
      .above   (above),
      .advance (advance),
      .rsp     (rsp)
   );

endmodule

FILE: hdl/rmd_line_ram.sv
// single-port synchronous RAM, registered read data
module rmd_line_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem[addr] <= wdata;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (en && !we) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/rmd_scan_ctrl.sv
// raster position counters, line buffer access and word tagging
module rmd_scan_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  rmd_pkg::dim_type      image_width,
   input  rmd_pkg::dim_type      image_height,
   input  logic                  advance,
   rmd_req_if.sink               req,
   output rmd_pkg::ram_cmd_type  ram_cmd,
   output rmd_pkg::tag_type      tag
);

   rmd_pkg::col_type   col_ff, col_in;
   rmd_pkg::row_type   row_ff, row_in;
   rmd_pkg::col_type   w_last, last_col;
   rmd_pkg::row_type   h_last, last_row;
   rmd_pkg::pixel_type pix;
   logic               accept;

   // clamp the dimensions and find the last index of each axis
   always_comb begin
      if (image_width < rmd_pkg::DIM_W'(2)) begin
         w_last = rmd_pkg::COL_W'(1);
      end else if (32'(image_width) > rmd_pkg::MAX_WIDTH) begin
         w_last = rmd_pkg::COL_W'(rmd_pkg::MAX_WIDTH - 1);
      end else begin
         w_last = rmd_pkg::COL_W'(image_width - rmd_pkg::DIM_W'(1));
      end
      if (image_height < rmd_pkg::DIM_W'(2)) begin
         h_last = rmd_pkg::ROW_W'(1);
      end else if (32'(image_height) > rmd_pkg::MAX_HEIGHT) begin
         h_last = rmd_pkg::ROW_W'(rmd_pkg::MAX_HEIGHT - 1);
      end else begin
         h_last = rmd_pkg::ROW_W'(image_height - rmd_pkg::DIM_W'(1));
      end
   end

   // last odd index: an odd trailing column or row is dropped
   assign last_col = w_last[0] ? w_last : w_last - rmd_pkg::COL_W'(1);
   assign last_row = h_last[0] ? h_last : h_last - rmd_pkg::ROW_W'(1);

   assign req.ready = advance;
   assign accept    = req.valid && advance;
   assign pix       = {req.chan3, req.chan2, req.chan1, req.chan0};

   // even rows fill the line buffer, odd rows read the pixel above
   always_comb begin
      ram_cmd.en    = accept;
      ram_cmd.we    = !row_ff[0];
      ram_cmd.addr  = col_ff;
      ram_cmd.wdata = pix;
   end

   always_comb begin
      tag.valid     = accept && row_ff[0];
      tag.odd_col   = col_ff[0];
      tag.frame_end = (col_ff == last_col) && (row_ff == last_row);
      tag.pix       = pix;
   end

   // raster counters with frame wrap
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == w_last) begin
            col_in = '0;
            row_in = (row_ff == h_last) ? '0 : row_ff + rmd_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + rmd_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

FILE: hdl/rmd_filter.sv
// vertical and horizontal averaging, output register
module rmd_filter (
   input  logic                clock,
   input  logic                reset,
   input  rmd_pkg::tag_type    tag,
   input  rmd_pkg::pixel_type  above,
   output logic                advance,
   rmd_rsp_if.source           rsp
);

   rmd_pkg::tag_type   s1_ff, s1_in;
   rmd_pkg::pixel_type held_ff, held_in;
   rmd_pkg::pixel_type out_pix_ff, out_pix_in;
   logic               out_end_ff, out_end_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rmd_pkg::pixel_type vert;
   rmd_pkg::pixel_type box;

   // stage moves unless it holds a result and the output is full and stalled
   assign advance = !s1_ff.valid || !s1_ff.odd_col || !rsp_valid_ff || rsp.ready;

   assign vert = rmd_pkg::avg_pixel(above, s1_ff.pix);
   assign box  = rmd_pkg::avg_pixel(held_ff, vert);

   always_comb begin
      s1_in        = advance ? tag : s1_ff;
      held_in      = held_ff;
      out_pix_in   = out_pix_ff;
      out_end_in   = out_end_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance && s1_ff.valid && !s1_ff.odd_col) begin
         held_in = vert;
      end
      if (advance && s1_ff.valid && s1_ff.odd_col) begin
         out_pix_in   = box;
         out_end_in   = s1_ff.frame_end;
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_ff        <= s1_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pix_ff      <= out_pix_in;
      out_end_ff      <= out_end_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_chan0 = out_pix_ff[7:0];
   assign rsp.out_chan1 = out_pix_ff[15:8];
   assign rsp.out_chan2 = out_pix_ff[23:16];
   assign rsp.out_chan3 = out_pix_ff[31:24];
   assign rsp.frame_end = out_end_ff;

endmodule

FILE: tb/tb_top.sv
module tb_top;

   localparam int unsigned CYCLE_LIMIT      = 600_000;
   localparam int unsigned DRAIN_CYCLES     = 8;
   localparam int unsigned HOLD_OFF_CYCLES  = 400;
   localparam int unsigned RANDOM_PIXELS    = 520;
   localparam int unsigned MAX_PHASE_PIXELS = 100;

   // one downsampled word as seen on the rsp channel
   typedef struct packed {
      logic [rmd_pkg::PIX_W-1:0] pix;
      logic                      frame_end;
   } mip_word_type;

   // tracks the frame position and line buffer, queues the mip pixels due
   class mip_level_checker;
      rmd_pkg::dim_type   width_reg  = 13'd2;
      rmd_pkg::dim_type   height_reg = 13'd2;
      rmd_pkg::pixel_type upper_row [rmd_pkg::MAX_WIDTH];
      rmd_pkg::pixel_type held_avg   = '0;
      int unsigned        col        = 0;
      int unsigned        row        = 0;
      mip_word_type       pending_mips [$];
      int unsigned        mismatches = 0;

      // out-of-range sizes act as the nearest legal size
      static function int unsigned span(rmd_pkg::dim_type v, int unsigned hi);
         if (v < 2) return 2;
         if (v > hi) return hi;
         return 32'(v);
      endfunction

      // per-byte (a+b+1)>>1
      function rmd_pkg::pixel_type mean4(rmd_pkg::pixel_type a, rmd_pkg::pixel_type b);
         rmd_pkg::pixel_type       r;
         logic [rmd_pkg::CHAN_W:0] s;
         for (int k = 0; k < rmd_pkg::NUM_CHAN; k++) begin
            s = a[k*rmd_pkg::CHAN_W +: rmd_pkg::CHAN_W]
                + b[k*rmd_pkg::CHAN_W +: rmd_pkg::CHAN_W] + 9'd1;
            r[k*rmd_pkg::CHAN_W +: rmd_pkg::CHAN_W] = s[rmd_pkg::CHAN_W:1];
         end
         return r;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      // any register write restarts the frame
      function void write_reg(logic idx, logic [31:0] value);
         if (idx == rmd_pkg::REG_IMAGE_WIDTH) width_reg = value[rmd_pkg::DIM_W-1:0];
         else height_reg = value[rmd_pkg::DIM_W-1:0];
         col = 0;
         row = 0;
      endfunction

      function void check_reg(logic idx, logic [31:0] got);
         logic [31:0] want;
         want = (idx == rmd_pkg::REG_IMAGE_WIDTH) ? 32'(width_reg) : 32'(height_reg);
         if (got !== want)
            flag($sformatf("csr read idx %0d: expected %0d, got %0d", idx, want, got));
      endfunction

      function void take_source_pixel(rmd_pkg::pixel_type pix);
         int unsigned        w, h, c, r;
         rmd_pkg::pixel_type v;
         mip_word_type       m;
         w = span(width_reg, rmd_pkg::MAX_WIDTH);
         h = span(height_reg, rmd_pkg::MAX_HEIGHT);
         c = (col >= w) ? w - 1 : col;
         r = (row >= h) ? h - 1 : row;
         if (r % 2 == 0) begin
            upper_row[c] = pix;
         end else begin
            v = mean4(upper_row[c], pix);
            if (c % 2 == 0) begin
               held_avg = v;
            end else begin
               m.pix       = mean4(held_avg, v);
               m.frame_end = (c == (w & ~1) - 1) && (r == (h & ~1) - 1);
               pending_mips.push_back(m);
            end
         end
         // advance raster position, wrap at frame end
         c++;
         if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
         end
         col = c;
         row = r;
      endfunction

      function void check_mip_pixel(mip_word_type got);
         mip_word_type want;
         if (pending_mips.size() == 0) begin
            flag($sformatf("unexpected mip pixel %h frame_end %b", got.pix, got.frame_end));
            return;
         end
         want = pending_mips.pop_front();
         if (got.pix !== want.pix || got.frame_end !== want.frame_end)
            flag($sformatf("mip pixel: expected %h frame_end %b, got %h frame_end %b",
                           want.pix, want.frame_end, got.pix, got.frame_end));
      endfunction

      function int unsigned outstanding();
         return pending_mips.size();
      endfunction
   endclass

   localparam rmd_pkg::pixel_type CORNER_PIX [8] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
      32'h01FF_00FE, 32'h00FE_01FF, 32'h0000_0001, 32'hFFFF_FF00
   };

   logic                           clock;
   logic                           reset;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [rmd_pkg::CSR_ADDR_W-1:0] paddr;
   logic [rmd_pkg::CSR_DATA_W-1:0] pwdata;
   logic [rmd_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   bit idle_on   = 1'b1;
   bit stall_req = 1'b0;

   mip_level_checker sb = new();

   rmd_req_if req_if ();
   rmd_rsp_if rsp_if ();

   rgba_mipmap_downsample_2x2_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      int unsigned cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // rsp side: check accepted words, random backpressure, one long hold-off
   initial begin
      int unsigned  hold_left;
      mip_word_type seen;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            seen.pix = {rsp_if.out_chan3, rsp_if.out_chan2, rsp_if.out_chan1,
                        rsp_if.out_chan0};
            seen.frame_end = rsp_if.frame_end;
            sb.check_mip_pixel(seen);
         end
         if (stall_req) begin
            hold_left = HOLD_OFF_CYCLES;
            stall_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !(idle_on && $urandom_range(99) < 30);
         end
      end
   end

   // APB write: setup, access, then idle with psel low
   task automatic csr_write(input logic idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.write_reg(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.check_reg(idx, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // drain, then set frame size and read it back
   task automatic configure(input logic [31:0] wval, input logic [31:0] hval);
      req_if.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(rmd_pkg::REG_IMAGE_WIDTH, wval);
      csr_write(rmd_pkg::REG_IMAGE_HEIGHT, hval);
      csr_read_check(rmd_pkg::REG_IMAGE_WIDTH);
      csr_read_check(rmd_pkg::REG_IMAGE_HEIGHT);
   endtask

   // offer one source pixel, with random idle cycles ahead of it
   task automatic push_pixel(input rmd_pkg::pixel_type pix);
      while (idle_on && $urandom_range(99) < 30) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.chan0 <= pix[7:0];
      req_if.chan1 <= pix[15:8];
      req_if.chan2 <= pix[23:16];
      req_if.chan3 <= pix[31:24];
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.take_source_pixel(pix);
   endtask

   initial begin
      int unsigned sent;
      int unsigned n;
      int unsigned wspan;
      logic [31:0] wv;
      logic [31:0] hv;
      sent = 0;
      reset        <= 1'b1;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      req_if.valid <= 1'b0;
      req_if.chan0 <= '0;
      req_if.chan1 <= '0;
      req_if.chan2 <= '0;
      req_if.chan3 <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sizes, then two 2x2 frames back to back across the wrap
      csr_read_check(rmd_pkg::REG_IMAGE_WIDTH);
      csr_read_check(rmd_pkg::REG_IMAGE_HEIGHT);
      foreach (CORNER_PIX[i]) push_pixel(CORNER_PIX[i]);

      // odd last column and odd last row are dropped
      configure(32'd3, 32'd3);
      repeat (9) push_pixel($urandom());

      // sizes below two act as two
      configure(32'd0, 32'd1);
      repeat (4) push_pixel($urandom());
      configure(32'd1, 32'd0);
      repeat (4) push_pixel($urandom());

      // random sizes and content; phase 2 fills the block, phase 4 runs flat out
      for (int phase = 0; sent < RANDOM_PIXELS; phase++) begin
         wv = $urandom_range(2, 24);
         hv = $urandom_range(2, 7);
         if ($urandom_range(9) == 0) wv = $urandom_range(0, 1);
         if ($urandom_range(9) == 0) hv = $urandom_range(0, 1);
         if (phase == 2) begin
            wv = 4;
            hv = 4;
         end
         if (phase == 4) begin
            wv = 16;
            hv = 6;
         end
         // junk above the register width must be ignored
         if ($urandom_range(1) == 1) begin
            wv = wv | ($urandom() & 32'hFFFF_E000);
            hv = hv | ($urandom() & 32'hFFFF_E000);
         end
         configure(wv, hv);
         idle_on = (phase != 4);
         wspan = mip_level_checker::span(wv[rmd_pkg::DIM_W-1:0], rmd_pkg::MAX_WIDTH);
         n = wspan * mip_level_checker::span(hv[rmd_pkg::DIM_W-1:0], rmd_pkg::MAX_HEIGHT)
             * $urandom_range(1, 2) + $urandom_range(0, wspan);
         if (n > MAX_PHASE_PIXELS) n = MAX_PHASE_PIXELS;
         if (phase == 2) stall_req = 1'b1;
         repeat (n) push_pixel($urandom());
         sent += n;
      end
      idle_on = 1'b1;

      req_if.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
